FILE: sv/sdq_pkg.sv
// Shared types, codes and the control store for the searchable deque.
`default_nettype none

package sdq_pkg;

  // Action codes carried by the action field
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_BACK   = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;
  localparam logic [2:0] ACT_CONTAINS   = 3'd5;
  localparam logic [2:0] ACT_READ_AT    = 3'd6;
  localparam logic [2:0] ACT_LENGTH     = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;

  localparam int UPC_W = 4;

  // Datapath commands, one per control word
  typedef enum logic [3:0] {
    CMD_NOP        = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_PUSH_FRONT = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_POP_FRONT  = 4'd4,
    CMD_CLEAR      = 4'd5,
    CMD_SCAN_INIT  = 4'd6,
    CMD_SCAN_READ  = 4'd7,
    CMD_SCAN_CMP   = 4'd8,
    CMD_READ_ISSUE = 4'd9,
    CMD_LOAD_RD    = 4'd10,
    CMD_SET_FULL   = 4'd11,
    CMD_SET_OOR    = 4'd12
  } sdq_cmd_t;

  // Sequencing modes
  typedef enum logic [1:0] {
    SQ_NEXT   = 2'd0,
    SQ_BRANCH = 2'd1,
    SQ_DONE   = 2'd2
  } sdq_seq_t;

  // Branch conditions
  typedef enum logic [1:0] {
    CND_FULL     = 2'd0,
    CND_SCAN_END = 2'd1,
    CND_MISS     = 2'd2,
    CND_POS_OOR  = 2'd3
  } sdq_cond_t;

  typedef struct packed {
    sdq_cmd_t           cmd;
    sdq_seq_t           seq;
    sdq_cond_t          cond;
    logic [UPC_W-1:0]   target;
  } sdq_uword_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic full;
    logic scan_end;
    logic hit;
    logic pos_oor;
  } sdq_flags_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic     start;
    logic     exec;
    logic     done;
    sdq_cmd_t cmd;
  } sdq_ctl_t;

  // Result fields (next values) from the datapath
  typedef struct packed {
    logic signed [31:0] rd;
    logic               found;
    logic [1:0]         status;
  } sdq_res_t;

  // Control store addresses
  localparam logic [UPC_W-1:0] U_PB_CHK   = 4'd0;
  localparam logic [UPC_W-1:0] U_PB       = 4'd1;
  localparam logic [UPC_W-1:0] U_PF_CHK   = 4'd2;
  localparam logic [UPC_W-1:0] U_PF       = 4'd3;
  localparam logic [UPC_W-1:0] U_FULL     = 4'd4;
  localparam logic [UPC_W-1:0] U_POPB     = 4'd5;
  localparam logic [UPC_W-1:0] U_POPF     = 4'd6;
  localparam logic [UPC_W-1:0] U_CLR      = 4'd7;
  localparam logic [UPC_W-1:0] U_LEN      = 4'd8;
  localparam logic [UPC_W-1:0] U_SCAN0    = 4'd9;
  localparam logic [UPC_W-1:0] U_SCAN_RD  = 4'd10;
  localparam logic [UPC_W-1:0] U_SCAN_CMP = 4'd11;
  localparam logic [UPC_W-1:0] U_SCAN_HIT = 4'd12;
  localparam logic [UPC_W-1:0] U_RD       = 4'd13;
  localparam logic [UPC_W-1:0] U_RD_LD    = 4'd14;
  localparam logic [UPC_W-1:0] U_OOR      = 4'd15;

  // Control store
  function automatic sdq_uword_t sdq_ucode(input logic [UPC_W-1:0] addr);
    sdq_uword_t w;
    w = '{cmd: CMD_NOP, seq: SQ_DONE, cond: CND_FULL, target: U_LEN};
    case (addr)
      U_PB_CHK:   w = '{cmd: CMD_NOP,        seq: SQ_BRANCH, cond: CND_FULL,     target: U_FULL};
      U_PB:       w = '{cmd: CMD_PUSH_BACK,  seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_PF_CHK:   w = '{cmd: CMD_NOP,        seq: SQ_BRANCH, cond: CND_FULL,     target: U_FULL};
      U_PF:       w = '{cmd: CMD_PUSH_FRONT, seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_FULL:     w = '{cmd: CMD_SET_FULL,   seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_POPB:     w = '{cmd: CMD_POP_BACK,   seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_POPF:     w = '{cmd: CMD_POP_FRONT,  seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_CLR:      w = '{cmd: CMD_CLEAR,      seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_LEN:      w = '{cmd: CMD_NOP,        seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_SCAN0:    w = '{cmd: CMD_SCAN_INIT,  seq: SQ_NEXT,   cond: CND_FULL,     target: U_LEN};
      U_SCAN_RD:  w = '{cmd: CMD_SCAN_READ,  seq: SQ_BRANCH, cond: CND_SCAN_END, target: U_LEN};
      U_SCAN_CMP: w = '{cmd: CMD_SCAN_CMP,   seq: SQ_BRANCH, cond: CND_MISS,
                        target: U_SCAN_RD};
      U_SCAN_HIT: w = '{cmd: CMD_NOP,        seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_RD:       w = '{cmd: CMD_READ_ISSUE, seq: SQ_BRANCH, cond: CND_POS_OOR,  target: U_OOR};
      U_RD_LD:    w = '{cmd: CMD_LOAD_RD,    seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      U_OOR:      w = '{cmd: CMD_SET_OOR,    seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
      default:    w = '{cmd: CMD_NOP,        seq: SQ_DONE,   cond: CND_FULL,     target: U_LEN};
    endcase
    return w;
  endfunction

  // Entry point of each action's routine
  function automatic logic [UPC_W-1:0] sdq_entry(input logic [2:0] act);
    logic [UPC_W-1:0] a;
    a = U_LEN;
    case (act)
      ACT_PUSH_BACK:  a = U_PB_CHK;
      ACT_PUSH_FRONT: a = U_PF_CHK;
      ACT_POP_BACK:   a = U_POPB;
      ACT_POP_FRONT:  a = U_POPF;
      ACT_CLEAR:      a = U_CLR;
      ACT_CONTAINS:   a = U_SCAN0;
      ACT_READ_AT:    a = U_RD;
      ACT_LENGTH:     a = U_LEN;
      default:        a = U_LEN;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sdq_seq.sv
// Microcode sequencer: step counter, control store lookup and branching.
`default_nettype none

module sdq_seq
  import sdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [2:0] action,
  output logic            in_stall,
  input  wire sdq_flags_t flags,
  input  wire logic       out_blocked,
  output sdq_ctl_t        ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t           state;
  logic [UPC_W-1:0] upc;
  sdq_uword_t       word;
  logic             cond_true;
  logic             hold;
  logic             start;
  logic             exec;

  assign word     = sdq_ucode(upc);
  assign in_stall = (state != S_IDLE);
  assign start    = in_valid && (state == S_IDLE);
  // last step waits while the output register is still occupied
  assign hold     = (word.seq == SQ_DONE) && out_blocked;
  assign exec     = (state == S_RUN) && !hold;

  // condition select
  always_comb begin
    case (word.cond)
      CND_FULL:     cond_true = flags.full;
      CND_SCAN_END: cond_true = flags.scan_end;
      CND_MISS:     cond_true = !flags.hit;
      CND_POS_OOR:  cond_true = flags.pos_oor;
      default:      cond_true = 1'b0;
    endcase
  end

  assign ctl.start = start;
  assign ctl.exec  = exec;
  assign ctl.done  = exec && (word.seq == SQ_DONE);
  assign ctl.cmd   = word.cmd;

  // step counter and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      upc   <= U_LEN;
    end else if (start) begin
      state <= S_RUN;
      upc   <= sdq_entry(action);
    end else if (exec) begin
      case (word.seq)
        SQ_NEXT:   upc <= upc + 1'b1;
        SQ_BRANCH: upc <= cond_true ? word.target : upc + 1'b1;
        SQ_DONE:   state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sdq_dp.sv
// Datapath: ring store, head and count, scan index and working result registers.
`default_nettype none

module sdq_dp
  import sdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sdq_ctl_t                    ctl,
  input  wire logic signed [31:0]          value,
  input  wire logic [7:0]                  position,
  output sdq_flags_t                       flags,
  output sdq_res_t                         res,
  output logic [$clog2(DEPTH+1)-1:0]       length_next
);

  localparam int IW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);
  localparam int OW = (LW > 8) ? LW : 8;
  localparam int SW = OW + 1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic signed [31:0] value_r;
  logic [7:0]         pos_r;
  logic [IW-1:0]      head, head_next;
  logic [LW-1:0]      count, count_next;
  logic [LW-1:0]      idx, idx_next;
  logic signed [31:0] rd_w, rd_next;
  logic               found_w, found_next;
  logic [1:0]         status_w, status_next;
  logic               we;
  logic [IW-1:0]      waddr, raddr;
  logic [IW-1:0]      head_dec, head_inc;

  // ring slot of base plus offset, offset below DEPTH when used
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                         input logic [OW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[IW-1:0];
  endfunction

  assign head_dec = (head == '0) ? IW'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;

  // flags for the sequencer
  assign flags.full     = (count == LW'(DEPTH));
  assign flags.scan_end = (idx >= count);
  assign flags.hit      = (rdata == value_r);
  assign flags.pos_oor  = (OW'(pos_r) >= OW'(count));

  // next values per command
  always_comb begin
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    rd_next     = rd_w;
    found_next  = found_w;
    status_next = status_w;
    we          = 1'b0;
    waddr       = wrap(head, OW'(count));
    raddr       = wrap(head, OW'(idx));
    case (ctl.cmd)
      CMD_PUSH_BACK: begin
        we         = 1'b1;
        count_next = count + 1'b1;
      end
      CMD_PUSH_FRONT: begin
        we         = 1'b1;
        waddr      = head_dec;
        head_next  = head_dec;
        count_next = count + 1'b1;
      end
      CMD_POP_BACK: begin
        if (count != '0) count_next = count - 1'b1;
      end
      CMD_POP_FRONT: begin
        if (count != '0) begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      CMD_SCAN_INIT: begin
        idx_next   = '0;
        found_next = 1'b0;
      end
      CMD_SCAN_READ: begin
      end
      CMD_SCAN_CMP: begin
        found_next = flags.hit;
        idx_next   = idx + 1'b1;
      end
      CMD_READ_ISSUE: begin
        raddr = wrap(head, OW'(pos_r));
      end
      CMD_LOAD_RD: begin
        rd_next = rdata;
      end
      CMD_SET_FULL: begin
        status_next = ST_FULL;
      end
      CMD_SET_OOR: begin
        rd_next     = -32'sd1;
        status_next = ST_OOR;
      end
      default: begin
      end
    endcase
  end

  assign res.rd      = rd_next;
  assign res.found   = found_next;
  assign res.status  = status_next;
  assign length_next = count_next;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.exec && we) mem[waddr] <= value_r;
  end

  // read data holds while a step waits on the output register
  always_ff @(posedge clk) begin
    if (ctl.exec) rdata <= mem[raddr];
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // per-transaction operands and working results
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      value_r  <= value;
      pos_r    <= position;
      idx      <= '0;
      rd_w     <= '0;
      found_w  <= 1'b0;
      status_w <= ST_OK;
    end else if (ctl.exec) begin
      idx      <= idx_next;
      rd_w     <= rd_next;
      found_w  <= found_next;
      status_w <= status_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LW'(DEPTH))
    else $error("count exceeds depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && (ctl.cmd == CMD_PUSH_BACK || ctl.cmd == CMD_PUSH_FRONT)
      |=> count == $past(count) + 1'b1)
    else $error("push did not grow the store");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= IW'(DEPTH - 1))
    else $error("head outside the ring");
`endif

endmodule

`default_nettype wire

FILE: sv/searchable_deque.sv
// Searchable deque top level: sequencer, datapath and output register.
// Contains walks the stored values through the store's registered read port,
// one entry per two microcode steps.
// One transaction is in work at a time; the next is accepted the cycle after the
// last step, even while the previous result still waits in the output register.
// Reset (rst, synchronous) empties the deque; stored values are not cleared.
`default_nettype none

module searchable_deque
  import sdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  action,
  input  wire logic signed [31:0]          value,
  input  wire logic [7:0]                  position,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [31:0]               read_value,
  output logic                             found,
  output logic [$clog2(DEPTH+1)-1:0]       length,
  output logic [1:0]                       status
);

  localparam int LW = $clog2(DEPTH+1);

  sdq_ctl_t     ctl;
  sdq_flags_t   flags;
  sdq_res_t     res;
  logic [LW-1:0] length_next;
  logic         out_blocked;

  assign out_blocked = out_valid && out_stall;

  sdq_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .action      (action),
    .in_stall    (in_stall),
    .flags       (flags),
    .out_blocked (out_blocked),
    .ctl         (ctl)
  );

  sdq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .value       (value),
    .position    (position),
    .flags       (flags),
    .res         (res),
    .length_next (length_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      read_value <= res.rd;
      found      <= res.found;
      length     <= length_next;
      status     <= res.status;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> !(out_valid && out_stall))
    else $error("result overwritten while held");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> length == LW'(DEPTH))
    else $error("full status with room left");

  a_oor_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OOR |-> read_value == -32'sd1 && !found)
    else $error("out of range read with bad value");
`endif

endmodule

`default_nettype wire
